// ----- design/mvd_pkg.sv -----
// ----------------------------------------------------------------------------
// mvd_pkg
// Shared constants, register codes and types of the magnetic vehicle detector.
// ----------------------------------------------------------------------------
package mvd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int LEAK_SHIFT  = 3;

    localparam int AVG_W    = SAMPLE_BITS + LEAK_SHIFT;
    localparam int CHG_W    = AVG_W + LEAK_SHIFT;
    localparam int MARGIN_W = 9;
    localparam int LEVEL_W  = 13;
    localparam int HOLD_W   = 8;
    localparam int CMP_W    = (AVG_W > LEVEL_W) ? AVG_W : LEVEL_W;
    localparam int RAIL_W   = ((SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W) + 1;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    localparam logic [MARGIN_W-1:0] RAIL_MARGIN_RST   = 9'd230;
    localparam logic [LEVEL_W-1:0]  DETECT_LEVEL_RST  = 13'd85;
    localparam logic [HOLD_W-1:0]   HOLDOFF_TICKS_RST = 8'd45;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        REG_RAIL_MARGIN   = 2'd0,
        REG_DETECT_LEVEL  = 2'd1,
        REG_HOLDOFF_TICKS = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        POT_NONE     = 2'd0,
        POT_DECREASE = 2'd1,
        POT_INCREASE = 2'd2
    } pot_action_t;

    typedef struct packed {
        logic [MARGIN_W-1:0] rail_margin;
        logic [LEVEL_W-1:0]  detect_level;
        logic [HOLD_W-1:0]   holdoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0] fast;
        logic [AVG_W-1:0] slow;
        logic [CHG_W-1:0] change;
    } filt_state_t;

endpackage

// ----- design/mvd_if.sv -----
// ----------------------------------------------------------------------------
// mvd_item_if / mvd_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mvd_item_if;
    import mvd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   command;
    logic                   channel;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output command, output channel, output sample,
                    input ready);
    modport sink   (input valid, input command, input channel, input sample,
                    output ready);
endinterface

interface mvd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] pot_action;
    logic       detected;
    logic       holdoff_active;

    modport source (output valid, output pot_action, output detected,
                    output holdoff_active, input ready);
    modport sink   (input valid, input pot_action, input detected,
                    input holdoff_active, output ready);
endinterface

// ----- design/mvd_regs.sv -----
// ----------------------------------------------------------------------------
// mvd_regs
// APB configuration registers: rail margin, detect level and holdoff reload.
// ----------------------------------------------------------------------------
module mvd_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [mvd_pkg::ADDR_W-1:0] paddr,
    input  logic [mvd_pkg::DATA_W-1:0] pwdata,
    output logic [mvd_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    output mvd_pkg::cfg_t         cfg
);
    import mvd_pkg::*;

    logic [MARGIN_W-1:0] rail_margin_reg;
    logic [LEVEL_W-1:0]  detect_level_reg;
    logic [HOLD_W-1:0]   holdoff_ticks_reg;
    logic                wr_en;
    reg_idx_t            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_margin_reg   <= RAIL_MARGIN_RST;
            detect_level_reg  <= DETECT_LEVEL_RST;
            holdoff_ticks_reg <= HOLDOFF_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RAIL_MARGIN:   rail_margin_reg   <= pwdata[MARGIN_W-1:0];
                REG_DETECT_LEVEL:  detect_level_reg  <= pwdata[LEVEL_W-1:0];
                REG_HOLDOFF_TICKS: holdoff_ticks_reg <= pwdata[HOLD_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RAIL_MARGIN:   prdata = DATA_W'(rail_margin_reg);
            REG_DETECT_LEVEL:  prdata = DATA_W'(detect_level_reg);
            REG_HOLDOFF_TICKS: prdata = DATA_W'(holdoff_ticks_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.rail_margin   = rail_margin_reg;
    assign cfg.detect_level  = detect_level_reg;
    assign cfg.holdoff_ticks = holdoff_ticks_reg;

endmodule

// ----- design/mvd_filter.sv -----
// ----------------------------------------------------------------------------
// mvd_filter
// Next state of one channel's fast, slow and change leaky integrators.
// ----------------------------------------------------------------------------
module mvd_filter (
    input  mvd_pkg::filt_state_t           cur,
    input  logic [mvd_pkg::SAMPLE_BITS-1:0] reading,
    output mvd_pkg::filt_state_t           nxt,
    output logic [mvd_pkg::AVG_W-1:0]      level
);
    import mvd_pkg::*;

    logic [AVG_W-1:0] fast_next;
    logic [AVG_W-1:0] slow_next;
    logic [AVG_W-1:0] diff;
    logic [CHG_W-1:0] change_next;

    always_comb
    begin
        fast_next   = cur.fast - (cur.fast >> LEAK_SHIFT) + AVG_W'(reading);
        slow_next   = cur.slow - (cur.slow >> LEAK_SHIFT) + (fast_next >> LEAK_SHIFT);
        diff        = (fast_next >= slow_next) ? (fast_next - slow_next)
                                               : (slow_next - fast_next);
        change_next = cur.change - (cur.change >> LEAK_SHIFT) + CHG_W'(diff);
    end

    assign nxt.fast   = fast_next;
    assign nxt.slow   = slow_next;
    assign nxt.change = change_next;
    assign level      = change_next[CHG_W-1:LEAK_SHIFT];

endmodule

// ----- design/magnetic_vehicle_detector.sv -----
// ----------------------------------------------------------------------------
// magnetic_vehicle_detector
// Two-channel magnetometer change detector with rail check and holdoff.
//
//   Channel    Direction  Handshake      Payload
//   item_in    in         valid/ready    command, channel, sample
//   result_out out        valid/ready    pot_action, detected, holdoff_active
//   APB        in         psel/penable   rail_margin, detect_level, holdoff_ticks
//
// Each item passes from transfer in through the input register to the result
// register, with the integrator update between the two; one item is accepted
// every cycle unless a stalled result holds both registers.
// Reset clears the integrators, the holdoff counter and both valid flags.
// A stalled result holds the input register; input is refused only while both
// registers are full and the result is not taken.
// ----------------------------------------------------------------------------
module magnetic_vehicle_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    mvd_item_if.sink                    item_in,
    mvd_result_if.source                result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mvd_pkg::DATA_W-1:0]  pwdata,
    output logic [mvd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import mvd_pkg::*;

    cfg_t                   cfg;

    logic                   s1_valid_reg;
    logic                   s1_command_reg;
    logic                   s1_channel_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    filt_state_t            filt_reg [2];
    logic [HOLD_W-1:0]      holdoff_reg;
    logic [HOLD_W-1:0]      holdoff_next;

    logic                   out_valid_reg;
    logic [1:0]             out_pot_reg;
    logic                   out_detected_reg;
    logic                   out_holdoff_reg;

    filt_state_t            filt_next;
    logic [AVG_W-1:0]       level;
    logic                   advance;
    logic                   is_sample;
    logic                   fire;
    logic                   rail_hi;
    logic                   rail_lo;
    pot_action_t            pot_next;

    mvd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mvd_filter u_filter (
        .cur     (filt_reg[s1_channel_reg]),
        .reading (s1_sample_reg),
        .nxt     (filt_next),
        .level   (level)
    );

    assign advance       = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !s1_valid_reg || advance;
    assign is_sample     = (s1_command_reg == CMD_SAMPLE);

    always_comb
    begin
        rail_hi = (RAIL_W'(s1_sample_reg) + RAIL_W'(cfg.rail_margin)) > RAIL_W'(FULL_SCALE);
        rail_lo = RAIL_W'(s1_sample_reg) < RAIL_W'(cfg.rail_margin);
        fire    = is_sample && (CMP_W'(level) > CMP_W'(cfg.detect_level))
                  && (holdoff_reg == '0);

        if (!is_sample)
            pot_next = POT_NONE;
        else if (rail_hi)
            pot_next = POT_DECREASE;
        else if (rail_lo)
            pot_next = POT_INCREASE;
        else
            pot_next = POT_NONE;

        if (!is_sample)
            holdoff_next = (holdoff_reg != '0) ? holdoff_reg - 1'b1 : holdoff_reg;
        else if (fire)
            holdoff_next = cfg.holdoff_ticks;
        else
            holdoff_next = holdoff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            holdoff_reg   <= '0;
            filt_reg[0]   <= '0;
            filt_reg[1]   <= '0;
        end
        else
        begin
            if (item_in.ready)
                s1_valid_reg <= item_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                holdoff_reg <= holdoff_next;
                if (is_sample)
                    filt_reg[s1_channel_reg] <= filt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            s1_command_reg <= item_in.command;
            s1_channel_reg <= item_in.channel;
            s1_sample_reg  <= item_in.sample;
        end
        if (advance)
        begin
            out_pot_reg      <= pot_next;
            out_detected_reg <= fire;
            out_holdoff_reg  <= (holdoff_next != '0);
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.pot_action     = out_pot_reg;
    assign result_out.detected       = out_detected_reg;
    assign result_out.holdoff_active = out_holdoff_reg;

endmodule

// ----- design/mvd_checker.sv -----
// ----------------------------------------------------------------------------
// mvd_port_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module mvd_port_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [1:0]                  result_pot_action,
    input logic                        result_detected,
    input logic                        result_holdoff_active,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mvd_pkg::ADDR_W-1:0]  paddr,
    input logic [mvd_pkg::DATA_W-1:0]  pwdata,
    input logic [mvd_pkg::DATA_W-1:0]  prdata
);
    import mvd_pkg::*;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite;

    // No result is offered while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // A new result rises only after an input transfer, via the input and result registers.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a matching input transfer");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid
            && $stable(result_pot_action) && $stable(result_detected)
            && $stable(result_holdoff_active)))
        else $error("stalled result changed");

    a_margin_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[3:2] == REG_RAIL_MARGIN) |=>
        (paddr[3:2] != REG_RAIL_MARGIN)
        || (prdata == DATA_W'($past(pwdata[MARGIN_W-1:0]))))
        else $error("rail margin readback mismatch");

    a_holdoff_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[3:2] == REG_HOLDOFF_TICKS) |=>
        (paddr[3:2] != REG_HOLDOFF_TICKS)
        || (prdata == DATA_W'($past(pwdata[HOLD_W-1:0]))))
        else $error("holdoff ticks readback mismatch");

endmodule

bind magnetic_vehicle_detector mvd_port_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .item_valid            (item_in.valid),
    .item_ready            (item_in.ready),
    .result_valid          (result_out.valid),
    .result_ready          (result_out.ready),
    .result_pot_action     (result_out.pot_action),
    .result_detected       (result_out.detected),
    .result_holdoff_active (result_out.holdoff_active),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata)
);
